>>> src/brb_pkg.sv
// Shared types and constants of the byte ring buffer with bursts.
package brb_pkg;

  // Command codes as they arrive on the input channel.
  localparam logic [3:0] CMD_OPEN_WR  = 4'd0;
  localparam logic [3:0] CMD_WR_BYTE  = 4'd1;
  localparam logic [3:0] CMD_OPEN_RD  = 4'd2;
  localparam logic [3:0] CMD_RD_BYTE  = 4'd3;
  localparam logic [3:0] CMD_OPEN_PK  = 4'd4;
  localparam logic [3:0] CMD_PK_BYTE  = 4'd5;
  localparam logic [3:0] CMD_SKIP     = 4'd6;
  localparam logic [3:0] CMD_COMMIT   = 4'd7;
  localparam logic [3:0] CMD_STATUS   = 4'd8;

  // Port widths of the request and result fields.
  localparam int CMD_W   = 4;
  localparam int LEN_W   = 16;
  localparam int BYTE_W  = 8;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = 13;
  localparam int IDX_W   = 12;
  // Width that holds any request length and any depth for compares.
  localparam int CMP_W   = 17;

  // Entries in the queue between front and back.
  localparam int QDEPTH  = 2;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_WRITE,
    KIND_READ,
    KIND_PEEK
  } kind_t;

  typedef enum logic [2:0] {
    OP_OPEN,
    OP_BYTE,
    OP_SKIP,
    OP_COMMIT,
    OP_NOP
  } op_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_SHORT,
    ST_TOO_LONG,
    ST_NO_BURST
  } status_t;

  // A classified request as it travels from the front to the back.
  typedef struct packed {
    op_t                op;
    kind_t              kind;
    logic               too_long;
    logic [LEN_W-1:0]   len;
    logic [BYTE_W-1:0]  data;
  } req_t;

endpackage

>>> src/brb_front.sv
// Front end: takes requests from the input channel and classifies them.
module brb_front #(
  parameter int DEPTH = 4096
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [3:0]              in_cmd,
  input  logic [15:0]             in_length,
  input  logic [7:0]              in_data_in,
  output logic                    fr_valid,
  output brb_pkg::req_t           fr_req,
  input  logic                    q_full
);
  import brb_pkg::*;

  logic  valid_r;
  req_t  req_r;
  req_t  req_nxt;
  logic  accept;
  logic  push;

  assign push     = valid_r && !q_full;
  assign in_stall = valid_r && q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    req_nxt.len      = in_length;
    req_nxt.data     = in_data_in;
    req_nxt.too_long = {1'b0, in_length} > CMP_W'(DEPTH);
    case (in_cmd)
      CMD_OPEN_WR: begin
        req_nxt.op   = OP_OPEN;
        req_nxt.kind = KIND_WRITE;
      end
      CMD_WR_BYTE: begin
        req_nxt.op   = OP_BYTE;
        req_nxt.kind = KIND_WRITE;
      end
      CMD_OPEN_RD: begin
        req_nxt.op   = OP_OPEN;
        req_nxt.kind = KIND_READ;
      end
      CMD_RD_BYTE: begin
        req_nxt.op   = OP_BYTE;
        req_nxt.kind = KIND_READ;
      end
      CMD_OPEN_PK: begin
        req_nxt.op   = OP_OPEN;
        req_nxt.kind = KIND_PEEK;
      end
      CMD_PK_BYTE: begin
        req_nxt.op   = OP_BYTE;
        req_nxt.kind = KIND_PEEK;
      end
      CMD_SKIP: begin
        req_nxt.op   = OP_SKIP;
        req_nxt.kind = KIND_NONE;
      end
      CMD_COMMIT: begin
        req_nxt.op   = OP_COMMIT;
        req_nxt.kind = KIND_NONE;
      end
      CMD_STATUS: begin
        req_nxt.op   = OP_NOP;
        req_nxt.kind = KIND_NONE;
      end
      default: begin
        // Unused codes report status only.
        req_nxt.op   = OP_NOP;
        req_nxt.kind = KIND_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (push) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= req_nxt;
    end
  end

  assign fr_valid = valid_r;
  assign fr_req   = req_r;

endmodule

>>> src/brb_queue.sv
// Short request queue between the front end and the back end.
module brb_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  brb_pkg::req_t           push_req,
  output logic                    full,
  input  logic                    pop,
  output logic                    q_valid,
  output brb_pkg::req_t           q_req
);
  import brb_pkg::*;

  localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW = $clog2(QDEPTH + 1);

  req_t            entries [QDEPTH];
  logic [QAW-1:0]  wr_ptr_r;
  logic [QAW-1:0]  rd_ptr_r;
  logic [QCW-1:0]  count_r;

  function automatic logic [QAW-1:0] ptr_inc(input logic [QAW-1:0] p);
    logic [QAW-1:0] r;
    if (p == QAW'(QDEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  assign full    = count_r == QCW'(QDEPTH);
  assign q_valid = count_r != '0;
  assign q_req   = entries[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr_r] <= push_req;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("request pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("request popped from an empty queue");

endmodule

>>> src/brb_back.sv
// Back end: ring buffer state, byte store and the registered result.
module brb_back #(
  parameter int DEPTH = 4096
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  input  brb_pkg::req_t           q_req,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_status,
  output logic [12:0]             out_length_done,
  output logic [7:0]              out_data_out,
  output logic                    out_last,
  output logic [12:0]             out_used_count,
  output logic [12:0]             out_free_count,
  output logic [12:0]             out_contig_read,
  output logic [12:0]             out_contig_write,
  output logic [11:0]             out_read_index,
  output logic [11:0]             out_write_index
);
  import brb_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  // Ring state.
  logic [PW-1:0]   rpos_r, rpos_nxt;
  logic [PW-1:0]   wpos_r, wpos_nxt;
  logic [CW-1:0]   fill_r, fill_nxt;
  logic [CW-1:0]   left_r, left_nxt;
  kind_t           kind_r, kind_nxt;
  logic [PW-1:0]   peek_r, peek_nxt;

  // Byte store.
  logic [7:0]      mem [DEPTH];
  logic [7:0]      rd_data_r;
  logic            wr_en;
  logic            rd_en;
  logic [PW-1:0]   rd_addr;

  // Result register.
  logic            out_valid_r;
  status_t         status_r, status_nxt;
  logic [CW-1:0]   done_r, done_nxt;
  logic            last_r, last_nxt;
  logic            rd_sel_r;
  logic [CW-1:0]   ofill_r;
  logic [PW-1:0]   orpos_r;
  logic [PW-1:0]   owpos_r;

  logic            go;
  logic [CMP_W-1:0] len_x;
  logic [CMP_W-1:0] fill_x;
  logic [CMP_W-1:0] free_x;
  logic [CMP_W-1:0] avail;
  status_t         chk;
  logic [CW-1:0]   len_c;

  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] pos,
                                             input logic [CW-1:0] n);
    logic [CW:0] s;
    s = (CW+1)'(pos) + (CW+1)'(n);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return PW'(s);
  endfunction

  // A request is carried out when the result register is free or being emptied.
  assign go    = q_valid && (!out_valid_r || !out_stall);
  assign q_pop = go;

  assign len_x  = {1'b0, q_req.len};
  assign fill_x = CMP_W'(fill_r);
  assign free_x = CMP_W'(DEPTH) - fill_x;
  assign len_c  = CW'(q_req.len);

  always_comb begin
    if ((q_req.op == OP_OPEN && q_req.kind == KIND_WRITE) || q_req.op == OP_COMMIT) begin
      avail = free_x;
    end else begin
      avail = fill_x;
    end
    if (q_req.too_long) begin
      chk = ST_TOO_LONG;
    end else if (len_x > avail) begin
      chk = ST_SHORT;
    end else begin
      chk = ST_OK;
    end
  end

  always_comb begin
    rpos_nxt   = rpos_r;
    wpos_nxt   = wpos_r;
    fill_nxt   = fill_r;
    left_nxt   = left_r;
    kind_nxt   = kind_r;
    peek_nxt   = peek_r;
    status_nxt = ST_OK;
    done_nxt   = '0;
    last_nxt   = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = rpos_r;
    if (go) begin
      case (q_req.op)
        OP_OPEN: begin
          // Any open closes the burst that was open, whether it passes or not.
          kind_nxt   = KIND_NONE;
          left_nxt   = '0;
          peek_nxt   = '0;
          status_nxt = chk;
          if (chk == ST_OK) begin
            done_nxt = len_c;
            if (q_req.len != '0) begin
              kind_nxt = q_req.kind;
              left_nxt = len_c;
            end
          end
        end
        OP_BYTE: begin
          if (kind_r != q_req.kind || left_r == '0) begin
            status_nxt = ST_NO_BURST;
          end else if (q_req.kind == KIND_WRITE && fill_r == CW'(DEPTH)) begin
            status_nxt = ST_SHORT;
          end else if (q_req.kind == KIND_READ && fill_r == '0) begin
            status_nxt = ST_SHORT;
          end else if (q_req.kind == KIND_PEEK && CW'(peek_r) >= fill_r) begin
            status_nxt = ST_SHORT;
          end else begin
            if (q_req.kind == KIND_WRITE) begin
              wr_en    = 1'b1;
              wpos_nxt = wrap_add(wpos_r, CW'(1));
              fill_nxt = fill_r + 1'b1;
            end else if (q_req.kind == KIND_READ) begin
              rd_en    = 1'b1;
              rd_addr  = rpos_r;
              rpos_nxt = wrap_add(rpos_r, CW'(1));
              fill_nxt = fill_r - 1'b1;
            end else begin
              rd_en    = 1'b1;
              rd_addr  = wrap_add(rpos_r, CW'(peek_r));
              peek_nxt = peek_r + 1'b1;
            end
            done_nxt = CW'(1);
            left_nxt = left_r - 1'b1;
            if (left_r == CW'(1)) begin
              last_nxt = 1'b1;
              kind_nxt = KIND_NONE;
              peek_nxt = '0;
            end
          end
        end
        OP_SKIP: begin
          status_nxt = chk;
          if (chk == ST_OK) begin
            rpos_nxt = wrap_add(rpos_r, len_c);
            fill_nxt = fill_r - len_c;
            done_nxt = len_c;
          end
        end
        OP_COMMIT: begin
          status_nxt = chk;
          if (chk == ST_OK) begin
            wpos_nxt = wrap_add(wpos_r, len_c);
            fill_nxt = fill_r + len_c;
            done_nxt = len_c;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rpos_r      <= '0;
      wpos_r      <= '0;
      fill_r      <= '0;
      left_r      <= '0;
      kind_r      <= KIND_NONE;
      peek_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rpos_r <= rpos_nxt;
      wpos_r <= wpos_nxt;
      fill_r <= fill_nxt;
      left_r <= left_nxt;
      kind_r <= kind_nxt;
      peek_r <= peek_nxt;
      if (go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      status_r <= status_nxt;
      done_r   <= done_nxt;
      last_r   <= last_nxt;
      rd_sel_r <= rd_en;
      ofill_r  <= fill_nxt;
      orpos_r  <= rpos_nxt;
      owpos_r  <= wpos_nxt;
    end
  end

  // The read data register only moves together with the result register.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wpos_r] <= q_req.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  logic [CW-1:0] ofree;
  logic [CW-1:0] rroom;
  logic [CW-1:0] wroom;
  logic [CW-1:0] crd;
  logic [CW-1:0] cwr;

  always_comb begin
    ofree = CW'(DEPTH) - ofill_r;
    rroom = CW'(DEPTH) - CW'(orpos_r);
    wroom = CW'(DEPTH) - CW'(owpos_r);
    crd   = (ofill_r < rroom) ? ofill_r : rroom;
    cwr   = (ofree < wroom) ? ofree : wroom;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_length_done  = CNT_W'(done_r);
  assign out_data_out     = rd_sel_r ? rd_data_r : 8'd0;
  assign out_last         = last_r;
  assign out_used_count   = CNT_W'(ofill_r);
  assign out_free_count   = CNT_W'(ofree);
  assign out_contig_read  = CNT_W'(crd);
  assign out_contig_write = CNT_W'(cwr);
  assign out_read_index   = IDX_W'(orpos_r);
  assign out_write_index  = IDX_W'(owpos_r);

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(DEPTH))
    else $error("fill count exceeds the depth");

  a_burst_open: assert property (@(posedge clk) disable iff (!rst_n)
    (kind_r == KIND_NONE) == (left_r == '0))
    else $error("burst kind and remaining length disagree");

  a_peek_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (peek_r != '0) |-> (kind_r == KIND_PEEK))
    else $error("peek offset set outside a peek burst");

endmodule

>>> src/byte_ring_buffer_bursts.sv
// Top level of the byte ring buffer with all-or-nothing bursts.
//
//   Channel  Direction  Handshake          Payload
//   in_      request    in_valid/in_stall  cmd, length, data_in
//   out_     result     out_valid/out_stall status, length_done, data_out, last,
//                                          counts, contig counts, indexes
//
// Every request yields one result, via the front register, the queue and the
// result register in turn. One request per cycle is sustained while out_stall
// is low: the back end updates the ring state and issues one store access per
// cycle, with the read data registered alongside the result. Reset is
// synchronous and clears the positions, counts and burst state; the byte store
// is not cleared. A two-entry queue separates front and back, so out_stall
// backs up into in_stall only after the queue and the front register are full.
module byte_ring_buffer_bursts #(
  parameter int DEPTH = 4096
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [3:0]   in_cmd,
  input  logic [15:0]  in_length,
  input  logic [7:0]   in_data_in,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [1:0]   out_status,
  output logic [12:0]  out_length_done,
  output logic [7:0]   out_data_out,
  output logic         out_last,
  output logic [12:0]  out_used_count,
  output logic [12:0]  out_free_count,
  output logic [12:0]  out_contig_read,
  output logic [12:0]  out_contig_write,
  output logic [11:0]  out_read_index,
  output logic [11:0]  out_write_index
);
  import brb_pkg::*;

  logic  fr_valid;
  req_t  fr_req;
  logic  q_full;
  logic  fr_push;
  logic  q_valid;
  req_t  q_req;
  logic  q_pop;

  assign fr_push = fr_valid && !q_full;

  brb_front #(
    .DEPTH (DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_cmd     (in_cmd),
    .in_length  (in_length),
    .in_data_in (in_data_in),
    .fr_valid   (fr_valid),
    .fr_req     (fr_req),
    .q_full     (q_full)
  );

  brb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fr_push),
    .push_req (fr_req),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_req    (q_req)
  );

  brb_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_req            (q_req),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_length_done  (out_length_done),
    .out_data_out     (out_data_out),
    .out_last         (out_last),
    .out_used_count   (out_used_count),
    .out_free_count   (out_free_count),
    .out_contig_read  (out_contig_read),
    .out_contig_write (out_contig_write),
    .out_read_index   (out_read_index),
    .out_write_index  (out_write_index)
  );

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the byte ring buffer with all-or-nothing bursts.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import brb_pkg::*;

  localparam int DEPTH = 4096;
  localparam logic [3:0] CMD_LAST = 4'hF;
  localparam int MAX_PRINTED = 40;

  typedef struct {
    status_t            status;
    logic [CNT_W-1:0]   length_done;
    logic [BYTE_W-1:0]  data_out;
    logic               last;
    logic [CNT_W-1:0]   used_count;
    logic [CNT_W-1:0]   free_count;
    logic [CNT_W-1:0]   contig_read;
    logic [CNT_W-1:0]   contig_write;
    logic [IDX_W-1:0]   read_index;
    logic [IDX_W-1:0]   write_index;
  } ring_result_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [CMD_W-1:0]   in_cmd;
  logic [LEN_W-1:0]   in_length;
  logic [BYTE_W-1:0]  in_data_in;
  logic               out_valid;
  logic               out_stall;
  logic [STAT_W-1:0]  out_status;
  logic [CNT_W-1:0]   out_length_done;
  logic [BYTE_W-1:0]  out_data_out;
  logic               out_last;
  logic [CNT_W-1:0]   out_used_count;
  logic [CNT_W-1:0]   out_free_count;
  logic [CNT_W-1:0]   out_contig_read;
  logic [CNT_W-1:0]   out_contig_write;
  logic [IDX_W-1:0]   out_read_index;
  logic [IDX_W-1:0]   out_write_index;

  // Shadow copy of the ring state.
  bit [7:0]     ring_mem [DEPTH];
  bit           written [DEPTH];
  int unsigned  ring_fill;
  int unsigned  ring_rd;
  int unsigned  ring_wr;
  int unsigned  burst_rem;
  int unsigned  peek_off;
  kind_t        burst_open;

  ring_result_t pending_results [$];
  int unsigned  run_left;
  int unsigned  work_items;
  int unsigned  directed_items;
  int unsigned  results_checked;
  int unsigned  bytes_returned;
  int unsigned  status_seen [4];
  int unsigned  errors;

  byte_ring_buffer_bursts #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_length        (in_length),
    .in_data_in       (in_data_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_length_done  (out_length_done),
    .out_data_out     (out_data_out),
    .out_last         (out_last),
    .out_used_count   (out_used_count),
    .out_free_count   (out_free_count),
    .out_contig_read  (out_contig_read),
    .out_contig_write (out_contig_write),
    .out_read_index   (out_read_index),
    .out_write_index  (out_write_index)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_error(input string msg);
    errors++;
    if (errors <= MAX_PRINTED) begin
      $display("ERROR at %0t ns: %s", $time, msg);
    end
  endtask

  function automatic int unsigned ring_add(input int unsigned p, input int unsigned n);
    return (p + n >= DEPTH) ? p + n - DEPTH : p + n;
  endfunction

  function automatic status_t len_check(input int unsigned n, input int unsigned room);
    if (n > DEPTH) return ST_TOO_LONG;
    if (n > room) return ST_SHORT;
    return ST_OK;
  endfunction

  function automatic kind_t kind_of(input logic [3:0] cmd);
    case (cmd)
      CMD_OPEN_WR, CMD_WR_BYTE: return KIND_WRITE;
      CMD_OPEN_RD, CMD_RD_BYTE: return KIND_READ;
      default:                  return KIND_PEEK;
    endcase
  endfunction

  // Applies one request to the shadow state and returns the result it must produce.
  function automatic ring_result_t ring_predict(input logic [3:0] cmd, input logic [15:0] len,
                                                input logic [7:0] din);
    ring_result_t r;
    kind_t        k;
    int unsigned  n;
    int unsigned  room;
    n = 32'(len);
    room = DEPTH - ring_fill;
    r.status = ST_OK;
    r.length_done = '0;
    r.data_out = '0;
    r.last = 1'b0;
    case (cmd)
      CMD_OPEN_WR, CMD_OPEN_RD, CMD_OPEN_PK: begin
        k = kind_of(cmd);
        // Any open closes the burst that was open, even when it is refused.
        burst_open = KIND_NONE;
        burst_rem = 0;
        peek_off = 0;
        r.status = len_check(n, (k == KIND_WRITE) ? room : ring_fill);
        if (r.status == ST_OK) begin
          r.length_done = CNT_W'(n);
          if (n != 0) begin
            burst_open = k;
            burst_rem = n;
          end
        end
      end
      CMD_WR_BYTE, CMD_RD_BYTE, CMD_PK_BYTE: begin
        k = kind_of(cmd);
        if (burst_open != k || burst_rem == 0) begin
          r.status = ST_NO_BURST;
        end else if (k == KIND_WRITE && room == 0) begin
          r.status = ST_SHORT;
        end else if (k == KIND_READ && ring_fill == 0) begin
          r.status = ST_SHORT;
        end else if (k == KIND_PEEK && peek_off >= ring_fill) begin
          r.status = ST_SHORT;
        end else begin
          case (k)
            KIND_WRITE: begin
              ring_mem[ring_wr] = din;
              written[ring_wr] = 1'b1;
              ring_wr = ring_add(ring_wr, 1);
              ring_fill++;
            end
            KIND_READ: begin
              r.data_out = ring_mem[ring_rd];
              ring_rd = ring_add(ring_rd, 1);
              ring_fill--;
            end
            default: begin
              r.data_out = ring_mem[ring_add(ring_rd, peek_off)];
              peek_off++;
            end
          endcase
          r.length_done = CNT_W'(1);
          burst_rem--;
          if (burst_rem == 0) begin
            r.last = 1'b1;
            burst_open = KIND_NONE;
            peek_off = 0;
          end
        end
      end
      CMD_SKIP: begin
        r.status = len_check(n, ring_fill);
        if (r.status == ST_OK) begin
          ring_rd = ring_add(ring_rd, n);
          ring_fill -= n;
          r.length_done = CNT_W'(n);
        end
      end
      CMD_COMMIT: begin
        r.status = len_check(n, room);
        if (r.status == ST_OK) begin
          ring_wr = ring_add(ring_wr, n);
          ring_fill += n;
          r.length_done = CNT_W'(n);
        end
      end
      default: begin
      end
    endcase
    room = DEPTH - ring_fill;
    r.used_count = CNT_W'(ring_fill);
    r.free_count = CNT_W'(room);
    r.contig_read = CNT_W'((ring_fill < DEPTH - ring_rd) ? ring_fill : DEPTH - ring_rd);
    r.contig_write = CNT_W'((room < DEPTH - ring_wr) ? room : DEPTH - ring_wr);
    r.read_index = IDX_W'(ring_rd);
    r.write_index = IDX_W'(ring_wr);
    return r;
  endfunction

  // Sends one request; the sender works in runs of random length, mostly with gaps between them.
  task automatic send_req(input logic [3:0] cmd, input logic [15:0] len, input logic [7:0] din);
    int unsigned gap;
    logic        hole;
    @(negedge clk);
    if (run_left == 0) begin
      run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    run_left--;
    hole = 1'b0;
    if (cmd == CMD_RD_BYTE && burst_open == KIND_READ && burst_rem != 0 && ring_fill != 0) begin
      hole = !written[ring_rd];
    end
    if (cmd == CMD_PK_BYTE && burst_open == KIND_PEEK && burst_rem != 0
        && peek_off < ring_fill) begin
      hole = !written[ring_add(ring_rd, peek_off)];
    end
    // Never read a byte that was only committed, never written; step over it instead.
    if (hole) begin
      cmd = CMD_SKIP;
      len = 16'd1;
    end
    pending_results.push_back(ring_predict(cmd, len, din));
    if (cmd < CMD_STATUS) work_items++;
    in_valid = 1'b1;
    in_cmd = cmd;
    in_length = len;
    in_data_in = din;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    int unsigned k;
    @(negedge clk);
    in_valid = 1'b0;
    k = 0;
    while (pending_results.size() != 0 && k < 100000) begin
      @(posedge clk);
      k++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic test_idle_commands();
    send_req(CMD_STATUS, 16'hFFFF, 8'hFF);
    send_req(CMD_LAST, 16'h0000, 8'h00);
    send_req(CMD_WR_BYTE, 16'h0001, 8'h5A);
    send_req(CMD_PK_BYTE, 16'h0001, 8'h00);
  endtask

  task automatic test_length_limits();
    send_req(CMD_OPEN_WR, 16'hFFFF, 8'h00);
    send_req(CMD_OPEN_RD, LEN_W'(DEPTH + 1), 8'h00);
    send_req(CMD_OPEN_RD, 16'd1, 8'h00);
    // A zero-length open is accepted but leaves no burst open.
    send_req(CMD_OPEN_WR, 16'd0, 8'h00);
  endtask

  task automatic test_burst_forms();
    send_req(CMD_OPEN_WR, 16'd3, 8'h00);
    send_req(CMD_WR_BYTE, 16'd0, 8'h00);
    send_req(CMD_WR_BYTE, 16'd0, 8'hFF);
    send_req(CMD_WR_BYTE, 16'd0, 8'hA5);
    send_req(CMD_OPEN_PK, 16'd2, 8'h00);
    send_req(CMD_PK_BYTE, 16'd0, 8'h00);
    send_req(CMD_PK_BYTE, 16'd0, 8'h00);
    send_req(CMD_OPEN_RD, 16'd2, 8'h00);
    send_req(CMD_RD_BYTE, 16'd0, 8'h00);
    // A new open replaces the read burst, so the next read byte is refused.
    send_req(CMD_OPEN_WR, 16'd1, 8'h00);
    send_req(CMD_RD_BYTE, 16'd0, 8'h00);
  endtask

  task automatic test_space_gone();
    send_req(CMD_OPEN_WR, 16'd1, 8'h00);
    send_req(CMD_COMMIT, LEN_W'(DEPTH - ring_fill), 8'h00);
    send_req(CMD_WR_BYTE, 16'd0, 8'h3C);
    send_req(CMD_COMMIT, LEN_W'(DEPTH + 1), 8'h00);
    send_req(CMD_SKIP, LEN_W'(DEPTH), 8'h00);
    send_req(CMD_WR_BYTE, 16'd0, 8'hC3);
    send_req(CMD_OPEN_RD, 16'd1, 8'h00);
    send_req(CMD_SKIP, 16'd1, 8'h00);
    send_req(CMD_RD_BYTE, 16'd0, 8'h00);
  endtask

  task automatic test_random_traffic(input int unsigned target);
    int unsigned start;
    int unsigned n;
    int unsigned avail;
    int unsigned i;
    int unsigned pick;
    int unsigned extra;
    kind_t       k;
    logic [3:0]  open_cmd;
    logic [3:0]  byte_cmd;
    logic [3:0]  cmd;
    logic [15:0] len;
    bit          drained;
    start = work_items;
    drained = 1'b0;
    while (work_items - start < target) begin
      if (!drained && work_items - start >= target / 2) begin
        wait_drained();
        drained = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // Burst with random content, sometimes too long, cut short, interrupted or overrun by one byte.
        if (ring_fill < 64) begin
          k = ($urandom_range(0, 4) == 0) ? KIND_PEEK : KIND_WRITE;
        end else if (ring_fill > DEPTH - 64) begin
          k = ($urandom_range(0, 1) == 0) ? KIND_READ : KIND_PEEK;
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 45) k = KIND_WRITE;
          else if (pick < 80) k = KIND_READ;
          else k = KIND_PEEK;
        end
        case (k)
          KIND_WRITE: begin
            open_cmd = CMD_OPEN_WR;
            byte_cmd = CMD_WR_BYTE;
            avail = DEPTH - ring_fill;
          end
          KIND_READ: begin
            open_cmd = CMD_OPEN_RD;
            byte_cmd = CMD_RD_BYTE;
            avail = ring_fill;
          end
          default: begin
            open_cmd = CMD_OPEN_PK;
            byte_cmd = CMD_PK_BYTE;
            avail = ring_fill;
          end
        endcase
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
        if (avail <= 64 && $urandom_range(0, 7) == 0) n = avail;
        if (n > avail && $urandom_range(0, 4) != 0) n = avail;
        extra = ($urandom_range(0, 9) == 0) ? 1 : 0;
        send_req(open_cmd, LEN_W'(n), BYTE_W'($urandom_range(0, 255)));
        for (i = 0; i < n + extra; i++) begin
          pick = $urandom_range(0, 99);
          if (pick < 2) break;
          if (pick < 6) begin
            case ($urandom_range(0, 3))
              0: send_req(CMD_STATUS, LEN_W'($urandom_range(0, 65535)),
                          BYTE_W'($urandom_range(0, 255)));
              1: send_req(CMD_SKIP, LEN_W'($urandom_range(0, 3)), 8'h00);
              2: send_req(CMD_COMMIT, LEN_W'($urandom_range(0, 3)), 8'h00);
              default: begin
                case ($urandom_range(0, 2))
                  0: cmd = CMD_WR_BYTE;
                  1: cmd = CMD_RD_BYTE;
                  default: cmd = CMD_PK_BYTE;
                endcase
                send_req(cmd, LEN_W'($urandom_range(0, 65535)),
                         BYTE_W'($urandom_range(0, 255)));
              end
            endcase
          end
          send_req(byte_cmd, LEN_W'($urandom_range(0, 65535)),
                   BYTE_W'($urandom_range(0, 255)));
        end
      end else if (pick < 82) begin
        // Moves of the positions, often around the limits of what fits.
        if (ring_fill > DEPTH / 2 || $urandom_range(0, 1) == 0) begin
          cmd = CMD_SKIP;
          avail = ring_fill;
        end else begin
          cmd = CMD_COMMIT;
          avail = DEPTH - ring_fill;
        end
        case ($urandom_range(0, 5))
          0: n = avail;
          1: n = avail + 1;
          2: n = DEPTH;
          3: n = DEPTH + 1;
          default: n = $urandom_range(0, avail);
        endcase
        send_req(cmd, LEN_W'(n), BYTE_W'($urandom_range(0, 255)));
      end else begin
        cmd = CMD_W'($urandom_range(0, CMD_LAST));
        case ($urandom_range(0, 3))
          0: len = LEN_W'($urandom_range(0, 65535));
          1: len = LEN_W'($urandom_range(0, 16));
          2: len = LEN_W'($urandom_range(DEPTH - 2, DEPTH + 2));
          default: len = ($urandom_range(0, 1) == 0) ? LEN_W'(ring_fill)
                                                      : LEN_W'(DEPTH - ring_fill);
        endcase
        send_req(cmd, len, BYTE_W'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic cmp_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want) begin
      report_error($sformatf("result %0d: %s is %0h, expected %0h",
                             results_checked, name, got, want));
    end
  endtask

  task automatic check_result();
    ring_result_t want;
    if (pending_results.size() == 0) begin
      report_error("result arrived with no request outstanding");
      return;
    end
    want = pending_results.pop_front();
    results_checked++;
    status_seen[want.status]++;
    if (want.length_done == 1 && want.status == ST_OK) bytes_returned++;
    cmp_field("status", out_status, want.status);
    cmp_field("length_done", out_length_done, want.length_done);
    cmp_field("data_out", out_data_out, want.data_out);
    cmp_field("last", out_last, want.last);
    cmp_field("used_count", out_used_count, want.used_count);
    cmp_field("free_count", out_free_count, want.free_count);
    cmp_field("contig_read", out_contig_read, want.contig_read);
    cmp_field("contig_write", out_contig_write, want.contig_write);
    cmp_field("read_index", out_read_index, want.read_index);
    cmp_field("write_index", out_write_index, want.write_index);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result();
  end

  // The receiver switches between stall patterns of random duration.
  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned tick;
    out_stall = 1'b0;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(40, 300);
      repeat (span) begin
        @(negedge clk);
        tick++;
        case (mode)
          0: out_stall = 1'b0;
          1: out_stall = ($urandom_range(0, 3) == 0);
          2: out_stall = ($urandom_range(0, 9) < 7);
          default: out_stall = (tick % 7) < 3;
        endcase
      end
    end
  end

  initial begin
    #5000000;
    $display("Timeout with %0d results still outstanding", pending_results.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_STATUS;
    in_length = '0;
    in_data_in = '0;
    ring_fill = 0;
    ring_rd = 0;
    ring_wr = 0;
    burst_rem = 0;
    peek_off = 0;
    burst_open = KIND_NONE;
    run_left = 0;
    work_items = 0;
    results_checked = 0;
    bytes_returned = 0;
    errors = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_idle_commands();
    test_length_limits();
    test_burst_forms();
    test_space_gone();
    directed_items = work_items;
    wait_drained();
    test_random_traffic(1800);
    wait_drained();

    if (pending_results.size() != 0) begin
      report_error($sformatf("%0d expected results never arrived", pending_results.size()));
    end
    $display("Checked %0d results from %0d requests (%0d directed), %0d single-byte transfers",
             results_checked, work_items, directed_items, bytes_returned);
    $display("Status mix: ok %0d, short %0d, too long %0d, no burst %0d; mismatches %0d",
             status_seen[ST_OK], status_seen[ST_SHORT], status_seen[ST_TOO_LONG],
             status_seen[ST_NO_BURST], errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> files.f
src/brb_pkg.sv
src/brb_front.sv
src/brb_queue.sv
src/brb_back.sv
src/byte_ring_buffer_bursts.sv
sim/testbench.sv
